// ===== hw/rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg: shared definitions for the memory scan compare filter
// Byte pair, configuration record, register indexes, operator codes and
// the window assembly and ordering functions.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned NUM_CELLS = 8;
  localparam int unsigned WIN_W     = 8 * NUM_CELLS;

  typedef logic [2:0] msc_idx_t;

  localparam msc_idx_t REG_BASE_ADDRESS     = 3'd0;
  localparam msc_idx_t REG_VALUE_WIDTH      = 3'd1;
  localparam msc_idx_t REG_SIGNED_COMPARE   = 3'd2;
  localparam msc_idx_t REG_BYTE_ORDER       = 3'd3;
  localparam msc_idx_t REG_COMPARE_OPERATOR = 3'd4;
  localparam msc_idx_t REG_COMPARE_SOURCE   = 3'd5;
  localparam msc_idx_t REG_COMPARE_CONSTANT = 3'd6;

  localparam logic [2:0] OP_LT = 3'd0;
  localparam logic [2:0] OP_LE = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_GE = 3'd3;
  localparam logic [2:0] OP_EQ = 3'd4;
  localparam logic [2:0] OP_NE = 3'd5;

  typedef struct packed {
    logic [7:0] now;
    logic [7:0] other;
  } msc_pair_t;

  typedef struct packed {
    logic [63:0] base_address;
    logic [1:0]  value_width;
    logic        signed_compare;
    logic        byte_order;
    logic [2:0]  compare_operator;
    logic        compare_source;
    logic [63:0] compare_constant;
  } msc_cfg_t;

  function automatic logic [3:0] msc_num_bytes(logic [1:0] wc);
    return 4'(4'd1 << wc);
  endfunction

  function automatic logic [WIN_W-1:0] msc_mask(logic [1:0] wc);
    logic [WIN_W-1:0] m;
    unique case (wc)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // The oldest byte of the window sits at the lowest address.
  function automatic logic [WIN_W-1:0] msc_assemble(logic [WIN_W-1:0] hist,
                                                    logic [1:0] wc,
                                                    logic big);
    logic [WIN_W-1:0] v;
    int unsigned n;
    n = 32'(msc_num_bytes(wc));
    v = '0;
    if (big) begin
      v = hist & msc_mask(wc);
    end else begin
      for (int unsigned i = 0; i < NUM_CELLS; i++) begin
        if (i < n) begin
          v[8*i +: 8] = hist[8*(n-1-i) +: 8];
        end
      end
    end
    return v;
  endfunction

  // Maps a value to a key whose unsigned order is the wanted order.
  function automatic logic [WIN_W-1:0] msc_key(logic [WIN_W-1:0] val,
                                               logic [1:0] wc,
                                               logic sgn);
    logic [WIN_W-1:0] m;
    logic [WIN_W-1:0] v;
    int unsigned n;
    m = msc_mask(wc);
    n = 32'(msc_num_bytes(wc));
    v = val & m;
    if (sgn) begin
      if (v[8*n-1]) begin
        v = v | ~m;
      end
      v[WIN_W-1] = ~v[WIN_W-1];
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/msc_cell.sv =====
// ----------------------------------------------------------------------------
// msc_cell: one byte position of the scan window
// Holds one byte of each snapshot stream and takes its neighbor's pair
// whenever a request is accepted.
// ----------------------------------------------------------------------------
module msc_cell
  import msc_pkg::*;
(
  input  logic      clk,
  input  logic      shift_en,
  input  msc_pair_t pair_in,
  output msc_pair_t pair_out
);

  msc_pair_t pair_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pair_r <= pair_in;
    end
  end

  assign pair_out = pair_r;

endmodule

// ===== hw/rtl/msc_cmp.sv =====
// ----------------------------------------------------------------------------
// msc_cmp: window compare
// Assembles the newest scanned window and the second stream's window or the
// constant, maps both to ordering keys and applies the selected operator.
// ----------------------------------------------------------------------------
module msc_cmp
  import msc_pkg::*;
(
  input  logic [WIN_W-1:0] hist_now,
  input  logic [WIN_W-1:0] hist_other,
  input  msc_cfg_t         cfg,
  output logic             match
);

  logic [WIN_W-1:0] key_a;
  logic [WIN_W-1:0] key_b;
  logic [WIN_W-1:0] operand_b;

  always_comb begin
    key_a = msc_key(msc_assemble(hist_now, cfg.value_width, cfg.byte_order),
                    cfg.value_width, cfg.signed_compare);
    if (cfg.compare_source) begin
      operand_b = msc_assemble(hist_other, cfg.value_width, cfg.byte_order);
    end else begin
      operand_b = cfg.compare_constant;
    end
    key_b = msc_key(operand_b, cfg.value_width, cfg.signed_compare);
  end

  always_comb begin
    unique case (cfg.compare_operator)
      OP_LT:   match = key_a < key_b;
      OP_LE:   match = key_a <= key_b;
      OP_GT:   match = key_a > key_b;
      OP_GE:   match = key_a >= key_b;
      OP_EQ:   match = key_a == key_b;
      OP_NE:   match = key_a != key_b;
      default: match = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/memory_scan_compare_filter.sv =====
// ----------------------------------------------------------------------------
// memory_scan_compare_filter: sliding window memory scan filter
// Streams memory bytes through a row of byte cells and reports the start
// address of every window whose compare holds.
// ----------------------------------------------------------------------------
// Each input request carries one byte of the scanned memory, the byte at
// the same address of a second snapshot and a scan start flag. Bytes enter
// a row of eight cells that shift once per accepted request. Once enough
// bytes for the configured value width have arrived since scan start, the
// window is compared in the following cycle and a match leaves as one
// output request holding the window's start address.
// One request is accepted per cycle while in_stall is low. A result moves
// from the compare stage register into the output register; requests that
// do not match produce none.
// When the output side stalls, one pending compare waits in the cells and
// the input is stalled until the output register frees up.
// Configuration writes are always ready and must only happen while idle.
// Synchronous reset clears the handshake state, the byte count, the window
// start address and the registers to their reset values (operator: equal).
// ----------------------------------------------------------------------------
module memory_scan_compare_filter
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_now,
  input  logic [7:0]  in_byte_other,
  input  logic        in_scan_start,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_match_address
);

  msc_cfg_t    cfg_r;
  logic [3:0]  seen_r, seen_nxt, seen_base;
  logic [63:0] start_r, start_nxt, start_base;
  logic        s1_valid_r, s1_valid_nxt;
  logic [63:0] s1_addr_r;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_addr_r;
  logic        advance;
  logic        accept;
  logic        fire;
  logic        match;
  logic [3:0]  num_bytes;
  msc_pair_t   chain [NUM_CELLS+1];
  logic [WIN_W-1:0] hist_now;
  logic [WIN_W-1:0] hist_other;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address     <= '0;
      cfg_r.value_width      <= '0;
      cfg_r.signed_compare   <= 1'b0;
      cfg_r.byte_order       <= 1'b0;
      cfg_r.compare_operator <= OP_EQ;
      cfg_r.compare_source   <= 1'b0;
      cfg_r.compare_constant <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:     cfg_r.base_address     <= cfg_wdata;
        REG_VALUE_WIDTH:      cfg_r.value_width      <= cfg_wdata[1:0];
        REG_SIGNED_COMPARE:   cfg_r.signed_compare   <= cfg_wdata[0];
        REG_BYTE_ORDER:       cfg_r.byte_order       <= cfg_wdata[0];
        REG_COMPARE_OPERATOR: cfg_r.compare_operator <= cfg_wdata[2:0];
        REG_COMPARE_SOURCE:   cfg_r.compare_source   <= cfg_wdata[0];
        REG_COMPARE_CONSTANT: cfg_r.compare_constant <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    num_bytes  = msc_num_bytes(cfg_r.value_width);
    seen_base  = in_scan_start ? 4'd0 : seen_r;
    start_base = in_scan_start ? cfg_r.base_address : start_r;
    start_nxt  = (seen_base >= num_bytes) ? start_base + 64'd1 : start_base;
    seen_nxt   = (seen_base < 4'(NUM_CELLS)) ? seen_base + 4'd1 : seen_base;
    fire       = seen_nxt >= num_bytes;
  end

  assign chain[0] = '{now: in_byte_now, other: in_byte_other};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    msc_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .pair_in  (chain[k]),
      .pair_out (chain[k+1])
    );
    assign hist_now[8*k +: 8]   = chain[k+1].now;
    assign hist_other[8*k +: 8] = chain[k+1].other;
  end

  msc_cmp u_cmp (
    .hist_now   (hist_now),
    .hist_other (hist_other),
    .cfg        (cfg_r),
    .match      (match)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = fire;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = s1_valid_r && match;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      start_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        seen_r  <= seen_nxt;
        start_r <= start_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= start_nxt;
    end
    if (advance && s1_valid_r) begin
      out_addr_r <= s1_addr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_addr_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the memory scan compare filter
// Streams memory bytes through the filter under random input gaps and output
// stalls, predicts every match address from a mirror of the registers and
// the byte windows, and checks each output request against it in order.
// ----------------------------------------------------------------------------
module tb;
  import msc_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_now = '0;
  logic [7:0]  in_byte_other = '0;
  logic        in_scan_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_match_address;

  msc_cfg_t    cfg_mirror;
  logic [63:0] trail_now;
  logic [63:0] trail_other;
  logic [63:0] window_addr;
  logic [3:0]  fill_count;
  logic [63:0] match_addrs_due[$];
  int          n_errors = 0;
  bit          steady_in = 1'b0;
  bit          hold_out = 1'b0;
  int          hold_run = 0;

  memory_scan_compare_filter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_now       (in_byte_now),
    .in_byte_other     (in_byte_other),
    .in_scan_start     (in_scan_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_address (out_match_address)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_mirror();
    cfg_mirror.base_address = '0;
    cfg_mirror.value_width = '0;
    cfg_mirror.signed_compare = 1'b0;
    cfg_mirror.byte_order = 1'b0;
    cfg_mirror.compare_operator = OP_EQ;
    cfg_mirror.compare_source = 1'b0;
    cfg_mirror.compare_constant = '0;
    trail_now = '0;
    trail_other = '0;
    window_addr = '0;
    fill_count = '0;
  endfunction

  function automatic logic [63:0] lane_mask(int n);
    return (n == 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // The oldest byte of the window belongs to the lowest address.
  function automatic logic [63:0] window_value(logic [63:0] trail, int n);
    logic [63:0] v;
    v = '0;
    if (cfg_mirror.byte_order) begin
      v = trail & lane_mask(n);
    end else begin
      for (int i = 0; i < n; i++) begin
        v[8*i +: 8] = trail[8*(n-1-i) +: 8];
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] widen(logic [63:0] v, int n);
    logic [63:0] m;
    m = lane_mask(n);
    v = v & m;
    if (cfg_mirror.signed_compare && v[8*n-1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

  function automatic bit compare_holds(logic [63:0] a, logic [63:0] b);
    bit lt;
    bit eq;
    eq = (a == b);
    lt = cfg_mirror.signed_compare ? ($signed(a) < $signed(b)) : (a < b);
    case (cfg_mirror.compare_operator)
      OP_LT:   return lt;
      OP_LE:   return lt || eq;
      OP_GT:   return !lt && !eq;
      OP_GE:   return !lt;
      OP_EQ:   return eq;
      OP_NE:   return !eq;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] b_now, logic [7:0] b_other, logic start);
    int n;
    logic [63:0] lhs;
    logic [63:0] rhs;
    n = 1 << cfg_mirror.value_width;
    if (start) begin
      trail_now = '0;
      trail_other = '0;
      fill_count = '0;
      window_addr = cfg_mirror.base_address;
    end
    trail_now = {trail_now[55:0], b_now};
    trail_other = {trail_other[55:0], b_other};
    if (fill_count >= n) begin
      window_addr = window_addr + 64'd1;
    end
    if (fill_count < 4'd8) begin
      fill_count = fill_count + 4'd1;
    end
    if (fill_count >= n) begin
      lhs = widen(window_value(trail_now, n), n);
      if (cfg_mirror.compare_source) begin
        rhs = widen(window_value(trail_other, n), n);
      end else begin
        rhs = widen(cfg_mirror.compare_constant, n);
      end
      if (compare_holds(lhs, rhs)) begin
        match_addrs_due.push_back(window_addr);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] due;
    if (!rst_n) begin
      reset_mirror();
    end else begin
      if (out_valid && !out_stall) begin
        if (match_addrs_due.size() == 0) begin
          $error("match_address: expected none, actual %h", out_match_address);
          n_errors++;
        end else begin
          due = match_addrs_due.pop_front();
          if (out_match_address !== due) begin
            $error("match_address: expected %h, actual %h", due, out_match_address);
            n_errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_ADDRESS:     cfg_mirror.base_address = cfg_wdata;
          REG_VALUE_WIDTH:      cfg_mirror.value_width = cfg_wdata[1:0];
          REG_SIGNED_COMPARE:   cfg_mirror.signed_compare = cfg_wdata[0];
          REG_BYTE_ORDER:       cfg_mirror.byte_order = cfg_wdata[0];
          REG_COMPARE_OPERATOR: cfg_mirror.compare_operator = cfg_wdata[2:0];
          REG_COMPARE_SOURCE:   cfg_mirror.compare_source = cfg_wdata[0];
          REG_COMPARE_CONSTANT: cfg_mirror.compare_constant = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_byte_now, in_byte_other, in_scan_start);
      end
    end
  end

  always @(posedge clk) begin : stall_gen
    int pick;
    if (hold_run == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        hold_out = 1'b0;
        hold_run = $urandom_range(1, 8);
      end else if (pick < 70) begin
        hold_out = 1'b1;
        hold_run = $urandom_range(1, 3);
      end else if (pick < 90) begin
        hold_out = 1'b0;
        hold_run = $urandom_range(20, 60);
      end else begin
        hold_out = 1'b1;
        hold_run = $urandom_range(10, 40);
      end
    end else begin
      hold_run--;
    end
    out_stall <= hold_out;
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_in || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b_now, input logic [7:0] b_other,
                           input logic start);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_now <= b_now;
    in_byte_other <= b_other;
    in_scan_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input msc_idx_t idx, input logic [63:0] value, input int bits);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= ({$urandom, $urandom} << bits) | value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setup(input msc_cfg_t s);
    write_reg(REG_BASE_ADDRESS, s.base_address, 64);
    write_reg(REG_VALUE_WIDTH, 64'(s.value_width), 2);
    write_reg(REG_SIGNED_COMPARE, 64'(s.signed_compare), 1);
    write_reg(REG_BYTE_ORDER, 64'(s.byte_order), 1);
    write_reg(REG_COMPARE_OPERATOR, 64'(s.compare_operator), 3);
    write_reg(REG_COMPARE_SOURCE, 64'(s.compare_source), 1);
    write_reg(REG_COMPARE_CONSTANT, s.compare_constant, 64);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (match_addrs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic msc_cfg_t make_setup(logic [63:0] base, logic [1:0] wc, logic sgn,
                                          logic big, logic [2:0] op, logic src,
                                          logic [63:0] k);
    msc_cfg_t s;
    s.base_address = base;
    s.value_width = wc;
    s.signed_compare = sgn;
    s.byte_order = big;
    s.compare_operator = op;
    s.compare_source = src;
    s.compare_constant = k;
    return s;
  endfunction

  function automatic logic [7:0] pick_byte(logic [63:0] k);
    int lane;
    lane = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4, 5:    return k[8*lane +: 8];
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic msc_cfg_t random_setup();
    msc_cfg_t s;
    case ($urandom_range(0, 3))
      0:       s.base_address = '0;
      1:       s.base_address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      default: s.base_address = {$urandom, $urandom};
    endcase
    s.value_width = 2'($urandom_range(0, 3));
    s.signed_compare = 1'($urandom_range(0, 1));
    s.byte_order = 1'($urandom_range(0, 1));
    s.compare_operator = 3'($urandom_range(0, 7));
    s.compare_source = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       s.compare_constant = '0;
      1:       s.compare_constant = 64'hFFFF_FFFF_FFFF_FFFF;
      2:       s.compare_constant = {8{pick_byte(64'h0)}};
      3:       s.compare_constant = 64'h80 << (8 * ((1 << s.value_width) - 1));
      default: s.compare_constant = {$urandom, $urandom};
    endcase
    return s;
  endfunction

  // Addresses count from zero until the first scan start arrives.
  task automatic test_unstarted_scan();
    send_byte(8'h00, 8'hFF, 1'b0);
    send_byte(8'hFF, 8'h00, 1'b0);
    send_byte(8'h00, 8'h5A, 1'b0);
    wait_drain();
  endtask

  task automatic test_operators();
    logic [2:0] op_list [0:7];
    op_list = '{OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ, OP_NE, OP_SPARE_LO, OP_SPARE_HI};
    for (int i = 0; i < 8; i++) begin
      load_setup(make_setup(64'h1000, 2'd0, 1'b1, 1'b0, op_list[i], 1'b1, 64'h0));
      send_byte(i[0] ? 8'h7F : 8'h80, 8'h7F, 1'b1);
      wait_drain();
    end
  endtask

  task automatic test_wrapping_window();
    load_setup(make_setup(64'hFFFF_FFFF_FFFF_FFFD, 2'd3, 1'b0, 1'b1, OP_NE, 1'b0, 64'h0));
    for (int i = 0; i < 10; i++) begin
      send_byte(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, i == 0);
    end
    wait_drain();
  endtask

  task automatic test_width_change();
    load_setup(make_setup(64'h0, 2'd1, 1'b1, 1'b0, OP_GE, 1'b0, 64'hABCD_0000_0000_8000));
    send_byte(8'h7F, 8'h80, 1'b0);
    send_byte(8'h80, 8'hFF, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_scans();
    int sent;
    int len;
    bit fresh;
    msc_cfg_t s;
    logic [7:0] b_now;
    logic [7:0] b_other;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drain();
      s = random_setup();
      load_setup(s);
      steady_in = ($urandom_range(0, 3) == 0);
      len = $urandom_range(30, 110);
      fresh = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        b_now = pick_byte(s.compare_constant);
        b_other = ($urandom_range(0, 1) == 1) ? b_now : pick_byte(s.compare_constant);
        send_byte(b_now, b_other, (i == 0 && fresh) || ($urandom_range(0, 24) == 0));
      end
      sent += len;
    end
    steady_in = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_unstarted_scan();
    test_operators();
    test_wrapping_window();
    test_width_change();
    test_random_scans();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
